// File: rtl/ffnl_pkg.sv
// Package for the frame forwarding and node liveness block.
// Holds the link count, beat types, command and action codes and the control states.
// No dependencies.
`default_nettype none

package ffnl_pkg;

  localparam int NUM_LINKS = 3;

  localparam logic [1:0] CMD_FRAME       = 2'd0;
  localparam logic [1:0] CMD_TICK        = 2'd1;
  localparam logic [1:0] CMD_TABLE_WRITE = 2'd2;
  localparam logic [1:0] CMD_LINK_STATE  = 2'd3;

  localparam logic [2:0] ACT_SWITCH    = 3'd0;
  localparam logic [2:0] ACT_BROADCAST = 3'd1;
  localparam logic [2:0] ACT_FORWARD   = 3'd2;
  localparam logic [2:0] ACT_DROP      = 3'd3;
  localparam logic [2:0] ACT_PING      = 3'd4;
  localparam logic [2:0] ACT_DEAD      = 3'd5;

  localparam logic [3:0] ADDR_SWITCH    = 4'h0;
  localparam logic [3:0] ADDR_BROADCAST = 4'hF;

  localparam logic [7:0] HOP_DIRECT = 8'd1;
  localparam logic [7:0] TICK_MAX   = 8'hFF;
  localparam logic [7:0] PING_RESET = 8'd3;
  localparam logic [7:0] DEAD_RESET = 8'd6;

  localparam logic REG_PING = 1'b0;
  localparam logic REG_DEAD = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic       is_control;
    logic [3:0] src_node;
    logic [3:0] dst_node;
    logic [1:0] link_index;
    logic [7:0] hop_count;
    logic       link_up;
  } item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] out_link;
    logic [2:0] link_mask;
    logic [3:0] node;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] ping_after_ticks;
    logic [7:0] dead_after_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_FRAME_LAST,
    ST_FRAME_DONE,
    ST_TICK_READ,
    ST_TICK_EVAL,
    ST_TICK_END
  } state_t;

endpackage

`default_nettype wire

// File: rtl/frame_forward_and_node_liveness.sv
// Frame forwarding and node liveness: a per-link table of hop counts and missed
// ticks, indexed by 4-bit node address, routes frame headers and ages direct
// neighbors on each tick. A frame header takes one read of the dual-read hop
// memory per link followed by a decide step; table writes and link state sets
// are applied when accepted; a tick does one read-modify-write of the table
// entry of each node but node 0 on every link in turn, and can stall on the
// result side. Both memories read as zero after reset through per-entry valid
// bits, so no clearing pass is needed. Depends on ffnl_pkg, ffnl_regs,
// ffnl_table, ffnl_ctrl.
`default_nettype none

module frame_forward_and_node_liveness
  import ffnl_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output result_t          result
);

  localparam int LINK_W = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int NODE_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ADDR_W = LINK_W + NODE_W;

  cfg_t              cfg;
  logic [ADDR_W-1:0] hop_ra_addr;
  logic [ADDR_W-1:0] hop_rb_addr;
  logic [7:0]        hop_ra_data;
  logic [7:0]        hop_rb_data;
  logic              hop_we;
  logic [ADDR_W-1:0] hop_waddr;
  logic [7:0]        hop_wdata;
  logic [ADDR_W-1:0] miss_raddr;
  logic [7:0]        miss_rdata;
  logic              miss_we;
  logic [ADDR_W-1:0] miss_waddr;
  logic [7:0]        miss_wdata;

  ffnl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffnl_table #(
    .NUM_LINKS   (NUM_LINKS),
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .hop_ra_addr (hop_ra_addr),
    .hop_rb_addr (hop_rb_addr),
    .hop_ra_data (hop_ra_data),
    .hop_rb_data (hop_rb_data),
    .hop_we      (hop_we),
    .hop_waddr   (hop_waddr),
    .hop_wdata   (hop_wdata),
    .miss_raddr  (miss_raddr),
    .miss_rdata  (miss_rdata),
    .miss_we     (miss_we),
    .miss_waddr  (miss_waddr),
    .miss_wdata  (miss_wdata)
  );

  ffnl_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .hop_ra_addr  (hop_ra_addr),
    .hop_rb_addr  (hop_rb_addr),
    .hop_ra_data  (hop_ra_data),
    .hop_rb_data  (hop_rb_data),
    .hop_we       (hop_we),
    .hop_waddr    (hop_waddr),
    .hop_wdata    (hop_wdata),
    .miss_raddr   (miss_raddr),
    .miss_rdata   (miss_rdata),
    .miss_we      (miss_we),
    .miss_waddr   (miss_waddr),
    .miss_wdata   (miss_wdata)
  );

endmodule

`default_nettype wire

// File: rtl/ffnl_regs.sv
// Configuration registers behind the APB-style port.
// Depends on ffnl_pkg for the register codes, reset values and cfg_t.
`default_nettype none

module ffnl_regs
  import ffnl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ping_after_ticks <= PING_RESET;
      cfg.dead_after_ticks <= DEAD_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PING: cfg.ping_after_ticks <= pwdata[7:0];
        REG_DEAD: cfg.dead_after_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PING: prdata = {24'd0, cfg.ping_after_ticks};
      REG_DEAD: prdata = {24'd0, cfg.dead_after_ticks};
      default:  prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/ffnl_table.sv
// Hop-count and missed-tick memories, one entry per link and node address.
// Registered reads; per-entry valid bits make unwritten entries read as zero.
// No package dependencies.
`default_nettype none

module ffnl_table #(
  parameter int NUM_LINKS   = 3,
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_W      = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ADDR_W-1:0] hop_ra_addr,
  input  wire logic [ADDR_W-1:0] hop_rb_addr,
  output logic      [7:0]        hop_ra_data,
  output logic      [7:0]        hop_rb_data,
  input  wire logic              hop_we,
  input  wire logic [ADDR_W-1:0] hop_waddr,
  input  wire logic [7:0]        hop_wdata,
  input  wire logic [ADDR_W-1:0] miss_raddr,
  output logic      [7:0]        miss_rdata,
  input  wire logic              miss_we,
  input  wire logic [ADDR_W-1:0] miss_waddr,
  input  wire logic [7:0]        miss_wdata
);

  localparam int NODE_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRIES = NUM_LINKS << NODE_W;

  logic [7:0]         hop_mem  [ENTRIES];
  logic [7:0]         miss_mem [ENTRIES];
  logic [ENTRIES-1:0] hop_vld;
  logic [ENTRIES-1:0] miss_vld;
  logic [7:0]         hop_qa;
  logic [7:0]         hop_qb;
  logic [7:0]         miss_q;
  logic               hop_va;
  logic               hop_vb;
  logic               miss_v;

  always_ff @(posedge clk) begin
    if (hop_we) begin
      hop_mem[hop_waddr] <= hop_wdata;
    end
    hop_qa <= hop_mem[hop_ra_addr];
    hop_qb <= hop_mem[hop_rb_addr];
  end

  always_ff @(posedge clk) begin
    if (miss_we) begin
      miss_mem[miss_waddr] <= miss_wdata;
    end
    miss_q <= miss_mem[miss_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_vld  <= '0;
      miss_vld <= '0;
      hop_va   <= 1'b0;
      hop_vb   <= 1'b0;
      miss_v   <= 1'b0;
    end else begin
      if (hop_we) begin
        hop_vld[hop_waddr] <= 1'b1;
      end
      if (miss_we) begin
        miss_vld[miss_waddr] <= 1'b1;
      end
      hop_va <= hop_vld[hop_ra_addr];
      hop_vb <= hop_vld[hop_rb_addr];
      miss_v <= miss_vld[miss_raddr];
    end
  end

  assign hop_ra_data = hop_va ? hop_qa : 8'd0;
  assign hop_rb_data = hop_vb ? hop_qb : 8'd0;
  assign miss_rdata  = miss_v ? miss_q : 8'd0;

endmodule

`default_nettype wire

// File: rtl/ffnl_ctrl.sv
// Sequencer for frame lookups, tick aging and table writes, with the result stage.
// Depends on ffnl_pkg; drives the memories in ffnl_table.
`default_nettype none

module ffnl_ctrl
  import ffnl_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_W      = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  cfg_t                   cfg,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output result_t                result,
  output logic      [ADDR_W-1:0] hop_ra_addr,
  output logic      [ADDR_W-1:0] hop_rb_addr,
  input  wire logic [7:0]        hop_ra_data,
  input  wire logic [7:0]        hop_rb_data,
  output logic                   hop_we,
  output logic      [ADDR_W-1:0] hop_waddr,
  output logic      [7:0]        hop_wdata,
  output logic      [ADDR_W-1:0] miss_raddr,
  input  wire logic [7:0]        miss_rdata,
  output logic                   miss_we,
  output logic      [ADDR_W-1:0] miss_waddr,
  output logic      [7:0]        miss_wdata
);

  localparam int LINK_W = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int NODE_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [LINK_W-1:0] LINK_LAST  = LINK_W'(NUM_LINKS - 1);
  localparam logic [NODE_W-1:0] NODE_LAST  = NODE_W'(TABLE_DEPTH - 1);
  localparam logic [NODE_W-1:0] NODE_FIRST = NODE_W'(1);

  state_t                state;
  state_t                state_next;
  logic [3:0]            frm_src;
  logic [3:0]            frm_dst;
  logic                  frm_ctrl;
  logic [LINK_W-1:0]     cnt;
  logic                  eval_vld;
  logic [LINK_W-1:0]     eval_link;
  logic                  src_found;
  logic [LINK_W-1:0]     src_link;
  logic                  dst_found;
  logic [LINK_W-1:0]     dst_link;
  logic [NUM_LINKS-1:0]  bc_mask;
  logic [LINK_W-1:0]     tlink;
  logic [NODE_W-1:0]     tnode;
  logic [NUM_LINKS-1:0]  link_known;
  logic                  pend_valid;
  result_t               pend;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  result_t               out_data;
  logic                  pend_load;
  logic                  pend_clear;
  logic                  tick_adv;
  logic                  src_in;
  logic                  dst_in;
  logic                  lidx_ok;
  logic                  wdst_ok;
  logic [7:0]            a_hop;
  logic [7:0]            b_hop;
  logic [ADDR_W-1:0]     tick_addr;
  logic [7:0]            m_inc;
  logic                  is_direct;
  logic                  go_dead;
  logic                  go_ping;
  logic                  tick_has;
  result_t               tick_res;
  result_t               frame_res;

  assign accept    = item_valid && item_ready;
  assign out_free  = !result_valid || result_ready;
  assign src_in    = ({1'b0, frm_src} < 5'(TABLE_DEPTH));
  assign dst_in    = ({1'b0, frm_dst} < 5'(TABLE_DEPTH));
  assign lidx_ok   = (4'(item.link_index) < 4'(NUM_LINKS));
  assign wdst_ok   = ({1'b0, item.dst_node} < 5'(TABLE_DEPTH));
  assign a_hop     = src_in ? hop_ra_data : 8'd0;
  assign b_hop     = dst_in ? hop_rb_data : 8'd0;
  assign tick_addr = {tlink, tnode};
  assign m_inc     = (miss_rdata == TICK_MAX) ? TICK_MAX : miss_rdata + 8'd1;
  assign is_direct = (hop_ra_data == HOP_DIRECT);
  assign go_dead   = (m_inc >= cfg.dead_after_ticks);
  assign go_ping   = (m_inc >= cfg.ping_after_ticks);
  assign tick_has  = is_direct && (go_dead || go_ping);

  always_comb begin
    tick_res           = '0;
    tick_res.action    = go_dead ? ACT_DEAD : ACT_PING;
    tick_res.out_link  = 2'(tlink);
    tick_res.node      = 4'(tnode);

    frame_res      = '0;
    frame_res.last = 1'b1;
    if (frm_dst == ADDR_SWITCH || frm_ctrl) begin
      frame_res.action = ACT_SWITCH;
    end else if (frm_dst == ADDR_BROADCAST) begin
      frame_res.action    = ACT_BROADCAST;
      frame_res.link_mask = 3'(bc_mask);
    end else if (dst_found) begin
      frame_res.action   = ACT_FORWARD;
      frame_res.out_link = 2'(dst_link);
    end else begin
      frame_res.action = ACT_DROP;
    end
  end

  always_comb begin
    state_next  = state;
    item_ready  = (state == ST_IDLE);
    out_load    = 1'b0;
    out_data    = pend;
    pend_load   = 1'b0;
    pend_clear  = 1'b0;
    tick_adv    = 1'b0;
    hop_we      = 1'b0;
    hop_waddr   = tick_addr;
    hop_wdata   = 8'd0;
    miss_we     = 1'b0;
    miss_waddr  = tick_addr;
    miss_wdata  = 8'd0;
    miss_raddr  = tick_addr;
    if (state == ST_TICK_READ || state == ST_TICK_EVAL) begin
      hop_ra_addr = tick_addr;
    end else begin
      hop_ra_addr = {cnt, NODE_W'(frm_src)};
    end
    hop_rb_addr = {cnt, NODE_W'(frm_dst)};

    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          unique case (item.cmd)
            CMD_FRAME: state_next = ST_FRAME;
            CMD_TICK:  state_next = ST_TICK_READ;
            CMD_TABLE_WRITE: begin
              hop_we    = lidx_ok && wdst_ok;
              hop_waddr = {LINK_W'(item.link_index), NODE_W'(item.dst_node)};
              hop_wdata = item.hop_count;
            end
            CMD_LINK_STATE: ;
            default: ;
          endcase
        end
      end
      ST_FRAME: begin
        if (cnt == LINK_LAST) begin
          state_next = ST_FRAME_LAST;
        end
      end
      ST_FRAME_LAST: begin
        state_next = ST_FRAME_DONE;
      end
      ST_FRAME_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data   = frame_res;
          miss_we    = src_found && frm_src != ADDR_SWITCH && frm_src != ADDR_BROADCAST;
          miss_waddr = {src_link, NODE_W'(frm_src)};
          miss_wdata = 8'd0;
          state_next = ST_IDLE;
        end
      end
      ST_TICK_READ: begin
        state_next = ST_TICK_EVAL;
      end
      ST_TICK_EVAL: begin
        if (!(tick_has && pend_valid && !out_free)) begin
          tick_adv = 1'b1;
          if (is_direct) begin
            miss_we    = 1'b1;
            miss_wdata = go_dead ? 8'd0 : m_inc;
            hop_we     = go_dead;
            hop_wdata  = 8'd0;
          end
          if (tick_has) begin
            pend_load = 1'b1;
            if (pend_valid) begin
              out_load = 1'b1;
              out_data = pend;
            end
          end
          if (tnode == NODE_LAST && tlink == LINK_LAST) begin
            state_next = ST_TICK_END;
          end else begin
            state_next = ST_TICK_READ;
          end
        end
      end
      ST_TICK_END: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_data      = pend;
          out_data.last = 1'b1;
          pend_clear    = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      link_known   <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      eval_vld     <= 1'b0;
    end else begin
      state    <= state_next;
      eval_vld <= (state == ST_FRAME);
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_clear) begin
        pend_valid <= 1'b0;
      end
      if (accept && item.cmd == CMD_LINK_STATE && lidx_ok) begin
        link_known[LINK_W'(item.link_index)] <= item.link_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.cmd == CMD_FRAME) begin
      frm_src   <= item.src_node;
      frm_dst   <= item.dst_node;
      frm_ctrl  <= item.is_control;
      cnt       <= '0;
      src_found <= 1'b0;
      dst_found <= 1'b0;
      bc_mask   <= '0;
    end else begin
      if (state == ST_FRAME) begin
        cnt <= cnt + LINK_W'(1);
      end
      if (eval_vld) begin
        if (!src_found && a_hop != 8'd0) begin
          src_found <= 1'b1;
          src_link  <= eval_link;
        end
        if (a_hop == 8'd0 && link_known[eval_link]) begin
          bc_mask[eval_link] <= 1'b1;
        end
        if (!dst_found && b_hop != 8'd0) begin
          dst_found <= 1'b1;
          dst_link  <= eval_link;
        end
      end
    end
    eval_link <= cnt;
    if (accept && item.cmd == CMD_TICK) begin
      tlink <= '0;
      tnode <= NODE_FIRST;
    end else if (tick_adv) begin
      if (tnode == NODE_LAST) begin
        tnode <= NODE_FIRST;
        tlink <= tlink + LINK_W'(1);
      end else begin
        tnode <= tnode + NODE_W'(1);
      end
    end
    if (out_load) begin
      result <= out_data;
    end
    if (pend_load) begin
      pend <= tick_res;
    end
  end

endmodule

`default_nettype wire
